@@ rtl/fdg_pkg.sv @@
// ----------------------------------------------------------------------------
// fdg_pkg
// Shared types and constants for the fractional delay line with glide.
// ----------------------------------------------------------------------------
package fdg_pkg;

    // Field widths fixed by the interface
    localparam int LEN_W = 21;
    localparam int CFG_W = 13;
    localparam int REQ_W = 2;

    // Parameter defaults
    localparam int DEF_DEPTH       = 4096;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_FRAC_BITS   = 8;

    // Result buffer
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PROCESS  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_GOAL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET_NOW  = 2'd2;

    // Per-stage control for one store read
    typedef struct packed {
        logic valid;  // item occupies this stage
        logic proc;   // item is a sample process request
        logic hit;    // entry read in this stage was written since reset
    } fdg_rd_t;

endpackage

@@ rtl/fdg_ram.sv @@
// ----------------------------------------------------------------------------
// fdg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read and write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module fdg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/fdg_ctrl.sv @@
// ----------------------------------------------------------------------------
// fdg_ctrl
// Request sequencer: delay glide and clamping, read address generation,
// write pointer and fill mark of the delay store, input flow control.
// ----------------------------------------------------------------------------
module fdg_ctrl #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [fdg_pkg::CFG_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fdg_pkg::REQ_W-1:0]    s_req_type,
    input  logic [SAMPLE_BITS-1:0]       s_sample_in,
    input  logic [fdg_pkg::LEN_W-1:0]    s_length_value,
    // result buffer occupancy
    input  logic [fdg_pkg::OUT_CNT_W-1:0] out_count,
    // store ports
    output logic                         ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]     ram_wr_addr,
    output logic [SAMPLE_BITS-1:0]       ram_wr_data,
    output logic                         ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]     ram_rd_addr,
    // to interpolator
    output fdg_pkg::fdg_rd_t             rd_a,
    output fdg_pkg::fdg_rd_t             rd_b,
    output logic [FRAC_BITS-1:0]         frac_a,
    output logic [fdg_pkg::LEN_W-1:0]    cur_len_a
);

    import fdg_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int LW   = $clog2(DEPTH + 1);
    localparam int DW   = LW + FRAC_BITS;
    localparam int EW   = ((DW > LEN_W) ? DW : LEN_W) + 1;
    localparam int CMPW = ((CFG_W > LW) ? CFG_W : LW) + 1;
    localparam int CW   = OUT_CNT_W + 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RD_A = 2'd1;
    localparam logic [1:0] PH_RD_B = 2'd2;

    localparam logic [DW-1:0] ONE_SAMPLE  = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] HALF_SAMPLE = DW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] RESET_LEN   = {LW'(DEPTH - 1), {FRAC_BITS{1'b0}}};

    logic [1:0]             phase_reg, phase_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [LW-1:0]          fill_reg, fill_next;
    logic [DW-1:0]          now_reg, now_next;
    logic [DW-1:0]          goal_reg, goal_next;
    logic                   proc_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [AW-1:0]          prev_reg;
    fdg_rd_t                rd_a_reg, rd_a_next;
    fdg_rd_t                rd_b_reg, rd_b_next;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [LEN_W-1:0]       cur_len_reg;

    logic                   accept;
    logic [CW-1:0]          in_flight;
    logic                   room;
    logic [EW-1:0]          lv_ext, hi_ext, clamped_ext;
    logic [DW-1:0]          clamped;
    logic [DW:0]            glide_up;
    logic [DW-1:0]          glide_dn, glided;
    logic [CMPW-1:0]        cfg_ext, cfg_clamp;
    logic [LW-1:0]          cfg_len;
    logic [LW-1:0]          whole, whole_c, rd_off;
    logic [LW:0]            idx_sum, idx_w;
    logic [AW-1:0]          idx, prev;
    logic [LW-1:0]          len_m1;
    logic                   do_write;

    // flow control: every accepted item must find a slot in the result buffer
    assign in_flight = CW'(phase_reg != PH_IDLE) + CW'(rd_b_reg.valid);
    assign room      = (CW'(out_count) + in_flight) < CW'(OUT_DEPTH);
    assign s_ready   = ((phase_reg == PH_IDLE) || (phase_reg == PH_RD_B)) && room;
    assign accept    = s_valid && s_ready;

    // clamp requested delay to one sample .. buffer length
    assign lv_ext      = EW'(s_length_value);
    assign hi_ext      = EW'({len_reg, {FRAC_BITS{1'b0}}});
    assign clamped_ext = (lv_ext < EW'(ONE_SAMPLE)) ? EW'(ONE_SAMPLE) :
                         (lv_ext > hi_ext)          ? hi_ext : lv_ext;
    assign clamped     = DW'(clamped_ext);

    // glide current delay toward target by at most half a sample
    assign glide_up = {1'b0, now_reg} + {1'b0, HALF_SAMPLE};
    assign glide_dn = now_reg - HALF_SAMPLE;
    always_comb begin
        glided = now_reg;
        if (now_reg < goal_reg) begin
            glided = (glide_up > {1'b0, goal_reg}) ? goal_reg : glide_up[DW-1:0];
        end else if (now_reg > goal_reg) begin
            glided = (glide_dn < goal_reg) ? goal_reg : glide_dn;
        end
    end

    // clamp register write to 2 .. DEPTH
    assign cfg_ext   = CMPW'(cfg_wr_data);
    assign cfg_clamp = (cfg_ext < CMPW'(2))     ? CMPW'(2) :
                       (cfg_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cfg_ext;
    assign cfg_len   = LW'(cfg_clamp);

    // read positions: write pointer minus the whole delay, and one further back
    assign whole   = now_reg[DW-1:FRAC_BITS];
    assign whole_c = (whole > len_reg) ? len_reg : whole;
    assign rd_off  = len_reg - whole_c;
    assign idx_sum = {1'b0, LW'(wp_reg)} + {1'b0, rd_off};
    assign idx_w   = (idx_sum >= {1'b0, len_reg}) ? (idx_sum - {1'b0, len_reg}) : idx_sum;
    assign idx     = idx_w[AW-1:0];
    assign len_m1  = len_reg - LW'(1);
    assign prev    = (idx == '0) ? len_m1[AW-1:0] : (idx - AW'(1));

    assign do_write = (phase_reg == PH_RD_B) && proc_reg;

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        now_next   = now_reg;
        goal_next  = goal_reg;
        rd_a_next  = '{valid: (phase_reg == PH_RD_A), proc: proc_reg,
                       hit: (LW'(idx) < fill_reg)};
        rd_b_next  = '{valid: (phase_reg == PH_RD_B), proc: proc_reg,
                       hit: (LW'(prev_reg) < fill_reg)};

        case (phase_reg)
            PH_IDLE: begin
                if (accept) begin
                    phase_next = PH_RD_A;
                end
            end
            PH_RD_A: begin
                phase_next = PH_RD_B;
            end
            PH_RD_B: begin
                phase_next = accept ? PH_RD_A : PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // store the new sample and advance the write pointer
        if (do_write) begin
            if (LW'(wp_reg) == fill_reg) begin
                fill_next = fill_reg + LW'(1);
            end
            wp_next = ((LW'(wp_reg) + LW'(1)) >= len_reg) ? '0 : (wp_reg + AW'(1));
        end

        if (accept) begin
            case (s_req_type)
                REQ_PROCESS: begin
                    now_next = glided;
                end
                REQ_SET_GOAL: begin
                    goal_next = clamped;
                end
                REQ_SET_NOW: begin
                    now_next  = clamped;
                    goal_next = clamped;
                end
                default: begin
                    now_next = now_reg;
                end
            endcase
        end

        // restart pointer and delay on a register write
        if (cfg_wr_en) begin
            len_next  = cfg_len;
            wp_next   = '0;
            now_next  = {cfg_len - LW'(1), {FRAC_BITS{1'b0}}};
            goal_next = {cfg_len - LW'(1), {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= LW'(DEPTH);
            wp_reg    <= '0;
            fill_reg  <= '0;
            now_reg   <= RESET_LEN;
            goal_reg  <= RESET_LEN;
            rd_a_reg  <= '0;
            rd_b_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            now_reg   <= now_next;
            goal_reg  <= goal_next;
            rd_a_reg  <= rd_a_next;
            rd_b_reg  <= rd_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            proc_reg   <= (s_req_type == REQ_PROCESS);
            sample_reg <= s_sample_in;
        end
        if (phase_reg == PH_RD_A) begin
            prev_reg    <= prev;
            frac_reg    <= now_reg[FRAC_BITS-1:0];
            cur_len_reg <= LEN_W'(now_reg);
        end
    end

    assign ram_wr_en   = do_write;
    assign ram_wr_addr = wp_reg;
    assign ram_wr_data = sample_reg;
    assign ram_rd_en   = proc_reg &&
                         ((phase_reg == PH_RD_A) || (phase_reg == PH_RD_B));
    assign ram_rd_addr = (phase_reg == PH_RD_A) ? idx : prev_reg;

    assign rd_a      = rd_a_reg;
    assign rd_b      = rd_b_reg;
    assign frac_a    = frac_reg;
    assign cur_len_a = cur_len_reg;

endmodule

@@ rtl/fdg_interp.sv @@
// ----------------------------------------------------------------------------
// fdg_interp
// Linear interpolation between the two neighboring stored samples.
// First product is taken when the newer sample arrives, the second and the
// rounding sum when the older one arrives.
// ----------------------------------------------------------------------------
module fdg_interp #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                      aclk,
    input  fdg_pkg::fdg_rd_t          rd_a,
    input  fdg_pkg::fdg_rd_t          rd_b,
    input  logic [FRAC_BITS-1:0]      frac_a,
    input  logic [fdg_pkg::LEN_W-1:0] cur_len_a,
    input  logic [SAMPLE_BITS-1:0]    rd_data,
    output logic                      push,
    output logic [SAMPLE_BITS-1:0]    push_sample,
    output logic [fdg_pkg::LEN_W-1:0] push_len
);

    import fdg_pkg::*;

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 1;

    localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS:0]     ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]          HALF = PW'(1) << (FRAC_BITS - 1);

    logic [SAMPLE_BITS-1:0] off_a, off_b;
    logic [FRAC_BITS:0]     wgt_a;
    logic [PW-1:0]          prod_a_reg;
    logic [FRAC_BITS-1:0]   frac_b_reg;
    logic [LEN_W-1:0]       len_b_reg;
    logic [PW-1:0]          prod_b, acc;
    logic [SAMPLE_BITS-1:0] result;

    // unwritten entries read as zero; flip sign to offset binary
    assign off_a = (rd_a.hit ? rd_data : '0) ^ SIGN;
    assign off_b = (rd_b.hit ? rd_data : '0) ^ SIGN;
    assign wgt_a = ONE - {1'b0, frac_a};

    always_ff @(posedge aclk) begin
        if (rd_a.valid) begin
            prod_a_reg <= PW'(PW'(off_a) * PW'(wgt_a));
            frac_b_reg <= frac_a;
            len_b_reg  <= cur_len_a;
        end
    end

    // round half up, then back to two's complement
    assign prod_b = PW'(PW'(off_b) * PW'(frac_b_reg));
    assign acc    = prod_a_reg + prod_b + HALF;
    assign result = acc[FRAC_BITS +: SAMPLE_BITS] ^ SIGN;

    assign push        = rd_b.valid;
    assign push_sample = rd_b.proc ? result : '0;
    assign push_len    = len_b_reg;

endmodule

@@ rtl/fdg_out_buf.sv @@
// ----------------------------------------------------------------------------
// fdg_out_buf
// Small result queue; decouples the result channel from the pipeline.
// ----------------------------------------------------------------------------
module fdg_out_buf #(
    parameter int WIDTH = 45
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [WIDTH-1:0]              push_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [WIDTH-1:0]              m_data,
    output logic [fdg_pkg::OUT_CNT_W-1:0] count
);

    import fdg_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);

    logic [WIDTH-1:0]     entry [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic                 pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + OUT_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = entry[rd_ptr_reg];
    assign count   = count_reg;

endmodule

@@ rtl/fractional_delay_line_glide_unit.sv @@
// Flow: a new request is taken once the first of the two reads of the delay
//   store through its single read port is done, and only while the result
//   queue has room.
// Reset (synchronous, aresetn low): pointer to 0, delay and target to
//   (DEPTH-1) samples, result queue empty; store entries not yet written
//   since reset read as zero through a fill mark, so no clearing pass.
// ----------------------------------------------------------------------------
// fractional_delay_line_glide_unit
// Circular delay line with gliding fractional delay and linear interpolation.
// ----------------------------------------------------------------------------
module fractional_delay_line_glide_unit #(
    parameter int DEPTH       = fdg_pkg::DEF_DEPTH,
    parameter int SAMPLE_BITS = fdg_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = fdg_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fdg_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fdg_pkg::REQ_W-1:0]     s_req_type,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic [fdg_pkg::LEN_W-1:0]     s_length_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic [fdg_pkg::LEN_W-1:0]     m_current_length
);

    import fdg_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = SAMPLE_BITS + LEN_W;

    logic                   ram_wr_en, ram_rd_en;
    logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_wr_data, ram_rd_data;
    fdg_rd_t                rd_a, rd_b;
    logic [FRAC_BITS-1:0]   frac_a;
    logic [LEN_W-1:0]       cur_len_a;
    logic                   push;
    logic [SAMPLE_BITS-1:0] push_sample;
    logic [LEN_W-1:0]       push_len;
    logic [OUT_CNT_W-1:0]   out_count;
    logic [OW-1:0]          m_data;

    fdg_ctrl #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_sample_in    (s_sample_in),
        .s_length_value (s_length_value),
        .out_count      (out_count),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .rd_a           (rd_a),
        .rd_b           (rd_b),
        .frac_a         (frac_a),
        .cur_len_a      (cur_len_a)
    );

    fdg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fdg_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .aclk        (aclk),
        .rd_a        (rd_a),
        .rd_b        (rd_b),
        .frac_a      (frac_a),
        .cur_len_a   (cur_len_a),
        .rd_data     (ram_rd_data),
        .push        (push),
        .push_sample (push_sample),
        .push_len    (push_len)
    );

    fdg_out_buf #(
        .WIDTH (OW)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_sample, push_len}),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (out_count)
    );

    assign m_sample_out     = m_data[OW-1:LEN_W];
    assign m_current_length = m_data[LEN_W-1:0];

    // result queue never receives a transfer it has no room for
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    // no request is taken while the previous one is on its first store read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one is reading the store");

    // every first read is followed by the second read of the same item
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_a.valid |=> (rd_b.valid && (rd_b.proc == $past(rd_a.proc))))
        else $error("interpolation stages out of step");

endmodule
